>>> design/wsfd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
`default_nettype none
package wsfd_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_CLOSE   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  // Field and register widths.
  localparam int unsigned FrameW = 20;
  localparam int unsigned MsgW   = 22;
  localparam int unsigned CfgW   = 22;

  // Configuration register indexes.
  localparam logic REG_MAX_FRAME   = 1'b0;
  localparam logic REG_MAX_MESSAGE = 1'b1;

  // Header decoding constants.
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_LAST    = 4'd3;

  // Depth of the queue between the parser and the output stage.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // One classified transaction handed from the parser to the output stage.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic       do_mask;
    logic       frame_last;
    logic       message_last;
  } wsfd_item_t;

endpackage
`default_nettype wire

>>> design/wsfd_front.sv
// Header parser and classifier: walks the frame header and tags payload bytes.
`default_nettype none
module wsfd_front
  import wsfd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic [FrameW-1:0] max_frame_len_i,
  input  wire logic [MsgW-1:0]   max_message_len_i,
  output logic                   push_o,
  output wsfd_item_t             item_o
);

  // Parser phases.
  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]        phase_q, phase_d;
  logic              fin_q, fin_d;
  logic              masked_q, masked_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [FrameW-1:0] len_q, len_d;
  logic              hi_q, hi_d;
  logic [FrameW-1:0] pos_q, pos_d;
  logic [MsgW-1:0]   total_q, total_d;
  logic              halted_q, halted_d;
  logic [7:0]        key_q [4];

  logic              key_we;
  logic [1:0]        key_idx;
  logic              len_done;
  logic              begin_pl;
  logic              chk_mask;
  logic              len_err;
  logic [FrameW-1:0] pos_inc;
  logic              flast;
  logic [MsgW:0]     msg_sum;

  // Sum of the message so far and this frame, one bit wider so it cannot wrap.
  assign msg_sum = {1'b0, total_q} + {{(MsgW + 1 - FrameW){1'b0}}, len_d};
  assign len_err = hi_d || (len_d > max_frame_len_i) || (msg_sum > {1'b0, max_message_len_i});
  assign pos_inc = pos_q + 1'b1;
  assign flast   = (pos_inc >= len_q);
  assign key_idx = cnt_q[1:0];

  // Next-state logic for one accepted byte.
  always_comb begin
    phase_d  = phase_q;
    fin_d    = fin_q;
    masked_d = masked_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    hi_d     = hi_q;
    pos_d    = pos_q;
    total_d  = total_q;
    halted_d = halted_q;
    key_we   = 1'b0;
    len_done = 1'b0;
    begin_pl = 1'b0;
    chk_mask = masked_q;
    push_o   = 1'b0;
    item_o   = '0;
    item_o.kind = KIND_PAYLOAD;

    if (accept_i && !halted_q) begin
      unique case (phase_q)
        PH_FIRST: begin
          fin_d = data_byte_i[7];
          if (data_byte_i[3:0] == OPC_CLOSE) begin
            halted_d    = 1'b1;
            push_o      = 1'b1;
            item_o.kind = KIND_CLOSE;
          end else begin
            phase_d = PH_SECOND;
          end
        end
        PH_SECOND: begin
          masked_d = data_byte_i[7];
          chk_mask = data_byte_i[7];
          hi_d     = 1'b0;
          if (data_byte_i[6:0] == LEN7_EXT16 || data_byte_i[6:0] == LEN7_EXT64) begin
            len_d   = '0;
            cnt_d   = (data_byte_i[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase_d = PH_EXTLEN;
          end else begin
            len_d    = {{(FrameW - 7){1'b0}}, data_byte_i[6:0]};
            len_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          // Bits shifted above the low field only matter as a too-long flag.
          len_d = {len_q[FrameW-9:0], data_byte_i};
          hi_d  = hi_q || (len_q[FrameW-1:FrameW-8] != 8'd0);
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == 4'd1) begin
            len_done = 1'b1;
          end
        end
        PH_KEY: begin
          key_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q >= KEY_LAST) begin
            begin_pl = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          push_o              = 1'b1;
          item_o.kind         = KIND_PAYLOAD;
          item_o.raw_byte     = data_byte_i;
          item_o.key_byte     = key_q[pos_q[1:0]];
          item_o.do_mask      = masked_q;
          item_o.frame_last   = flast;
          item_o.message_last = flast & fin_q;
          pos_d               = pos_inc;
          if (flast) begin
            total_d = fin_q ? '0 : msg_sum[MsgW-1:0] - {{(MsgW - FrameW){1'b0}}, len_d}
                                   + {{(MsgW - FrameW){1'b0}}, len_q};
            pos_d   = '0;
            phase_d = PH_FIRST;
          end
        end
        default: begin
          phase_d = PH_FIRST;
        end
      endcase

      // The full length is known: check the limits, then go on to the key or, unmasked, to the payload.
      if (len_done) begin
        if (len_err) begin
          halted_d    = 1'b1;
          push_o      = 1'b1;
          item_o.kind = KIND_ERROR;
        end else if (chk_mask) begin
          cnt_d   = '0;
          phase_d = PH_KEY;
        end else begin
          begin_pl = 1'b1;
        end
      end

      // Header done: start the payload, or for an empty frame go back to the header and report it if final.
      if (begin_pl) begin
        pos_d = '0;
        if (len_d == '0) begin
          phase_d = PH_FIRST;
          if (fin_q) begin
            total_d             = '0;
            push_o              = 1'b1;
            item_o.kind         = KIND_EMPTY;
            item_o.frame_last   = 1'b1;
            item_o.message_last = 1'b1;
          end
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
    end
  end

  // Control and header state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      fin_q    <= 1'b0;
      masked_q <= 1'b0;
      cnt_q    <= '0;
      len_q    <= '0;
      hi_q     <= 1'b0;
      pos_q    <= '0;
      total_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      hi_q     <= hi_d;
      pos_q    <= pos_d;
      total_q  <= total_d;
      halted_q <= halted_d;
    end
  end

  // Mask key bytes, always written in full before a masked payload reads them.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[key_idx] <= data_byte_i;
    end
  end

endmodule
`default_nettype wire

>>> design/wsfd_queue.sv
// Short queue of classified transactions between the parser and the output stage.
`default_nettype none
module wsfd_queue
  import wsfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire wsfd_item_t item_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output wsfd_item_t      item_o
);

  wsfd_item_t           slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slot_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

>>> design/wsfd_back.sv
// Output stage: unmasks payload bytes and holds the result transaction.
`default_nettype none
module wsfd_back
  import wsfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  wire wsfd_item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      payload_byte_o,
  output logic            frame_last_o,
  output logic            message_last_o
);

  logic       valid_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic       flast_q;
  logic       mlast_q;
  logic       load;

  // Refill the output register whenever it is empty or being drained.
  assign load  = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Result payload, unmasked on the way in.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= item_i.kind;
      byte_q  <= item_i.raw_byte ^ (item_i.do_mask ? item_i.key_byte : 8'd0);
      flast_q <= item_i.frame_last;
      mlast_q <= item_i.message_last;
    end
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = kind_q;
  assign payload_byte_o = byte_q;
  assign frame_last_o   = flast_q;
  assign message_last_o = mlast_q;

endmodule
`default_nettype wire

>>> design/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer: limit registers, parser, queue, output.
//
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_ready_o   data_byte_i
// output    out        out_valid_o / out_ready_i kind_o, payload_byte_o, frame_last_o,
//                                                message_last_o
// config    in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One byte is accepted per cycle while in_ready_o is high; the parser updates its
// header state in that cycle. A result is written into the two-entry queue at the edge
// that accepts its byte and is then loaded into the output register, where out_valid_o
// rises, once that register is empty or being drained. in_ready_o drops only while the
// queue is full, that is, while the output register holds a result that is not taken and
// two more wait behind it; it rises again once the output register is drained.
// Reset is asynchronous and clears all control state; limits return to their defaults.
// A close frame or a length violation halts the parser until reset.
`default_nettype none
module websocket_frame_deframer_unit
  import wsfd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      data_byte_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           payload_byte_o,
  output logic                 frame_last_o,
  output logic                 message_last_o,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i
);

  localparam logic [FrameW-1:0] FrameRst = FrameW'(BUFFER_BYTES % (2 ** FrameW));
  localparam logic [MsgW-1:0]   MsgRst   = MsgW'((BUFFER_BYTES * 4) % (2 ** MsgW));

  logic [FrameW-1:0] max_frame_q;
  logic [MsgW-1:0]   max_msg_q;
  logic              accept;
  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  wsfd_item_t        front_item;
  wsfd_item_t        queue_item;

  // Length limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= FrameRst;
      max_msg_q   <= MsgRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_FRAME:   max_frame_q <= cfg_data_i[FrameW-1:0];
        REG_MAX_MESSAGE: max_msg_q   <= cfg_data_i[MsgW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  // Header parser and classifier.
  wsfd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .data_byte_i      (data_byte_i),
    .max_frame_len_i  (max_frame_q),
    .max_message_len_i(max_msg_q),
    .push_o           (push),
    .item_o           (front_item)
  );

  // Decoupling queue.
  wsfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (queue_item)
  );

  // Output stage.
  wsfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .item_i        (queue_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .payload_byte_o(payload_byte_o),
    .frame_last_o  (frame_last_o),
    .message_last_o(message_last_o)
  );

endmodule
`default_nettype wire
